// File: hw/rtl/boq_pkg.sv
// Shared types and constants for the box occupancy query block.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package boq_pkg;

  // Doubled cell centers reach about +/-8.5e6, so 25 signed bits hold them.
  localparam int unsigned CoordW   = 25;
  // (2*col+1) is 11 bits wide and cell_size is 12 bits wide.
  localparam int unsigned ProdW    = 23;
  // Doubled box edges, 2*c +/- l, fit 18 signed bits.
  localparam int unsigned BoundW   = 18;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_POINT = 2'd2,
    MODE_CELL  = 2'd3
  } mode_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_X_ORIGIN  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_Y_TOP     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CELL_SIZE = 2'd2;

  localparam logic signed [15:0] XOriginRst  = -16'sd10000;
  localparam logic signed [15:0] YTopRst     = 16'sd10000;
  localparam logic        [11:0] CellSizeRst = 12'd100;

  typedef struct packed {
    mode_e              mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [15:0] len_x;
    logic        [15:0] len_y;
    logic        [9:0]  cell_row;
    logic        [9:0]  cell_col;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] first_slot;
    logic       table_full;
    logic [4:0] box_count;
  } out_t;

  // One stored box: center and full side lengths
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic        [15:0] lx;
    logic        [15:0] ly;
  } box_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic sum;
    logic scan;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic match;
    logic scan_end;
  } status_t;

endpackage

// File: hw/rtl/boq_dp.sv
// Datapath: config registers, box table memory, cell center math, scan compare.
// Depends on boq_pkg; driven by boq_ctrl through cmd_t / status_t.
`timescale 1ns / 1ps

module boq_dp #(
  parameter int unsigned MaxBoxes = 16,
  parameter int unsigned IdxW     = 4,
  parameter int unsigned CntW     = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [boq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [boq_pkg::CfgDataW-1:0]     cfg_data_i,
  input  boq_pkg::in_t                     in_i,
  input  boq_pkg::cmd_t                    cmd_i,
  output boq_pkg::status_t                 status_o,
  output boq_pkg::out_t                    res_o
);
  import boq_pkg::*;

  logic signed [15:0]       xo_q, yt_q;
  logic        [11:0]       cs_q;
  in_t                      in_q;
  logic        [ProdW-1:0]  prod_x_q, prod_y_q;
  logic signed [CoordW-1:0] x2_q, y2_q, x2_d, y2_d;
  box_t                     mem [MaxBoxes];
  box_t                     rd_data_q;
  box_t                     new_box;
  logic        [CntW-1:0]   cnt_q, cnt_d;
  logic        [CntW-1:0]   rd_idx_q;
  logic        [IdxW-1:0]   cmp_idx_q;
  logic                     cmp_vld_q;
  logic                     full;
  logic                     is_query;
  logic                     in_box;
  logic                     finish_upd, finish_scan;
  logic signed [BoundW-1:0] lo_x, hi_x, lo_y, hi_y;
  out_t                     res_q, res_d;

  assign full     = (cnt_q == CntW'(MaxBoxes));
  assign is_query = (in_q.mode == MODE_POINT) || (in_q.mode == MODE_CELL);

  assign new_box.cx = in_q.pos_x;
  assign new_box.cy = in_q.pos_y;
  assign new_box.lx = in_q.len_x;
  assign new_box.ly = in_q.len_y;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xo_q <= XOriginRst;
      yt_q <= YTopRst;
      cs_q <= CellSizeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_ORIGIN:  xo_q <= cfg_data_i;
        CFG_Y_TOP:     yt_q <= cfg_data_i;
        CFG_CELL_SIZE: cs_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Payload capture and cell-center math: products first, then the sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_i;
    end
    if (cmd_i.prep) begin
      prod_x_q <= ProdW'({in_q.cell_col, 1'b1}) * ProdW'(cs_q);
      prod_y_q <= ProdW'({in_q.cell_row, 1'b1}) * ProdW'(cs_q);
    end
    if (cmd_i.sum) begin
      x2_q <= x2_d;
      y2_q <= y2_d;
    end
  end

  always_comb begin
    if (in_q.mode == MODE_POINT) begin
      x2_d = CoordW'(signed'({in_q.pos_x, 1'b0}));
      y2_d = CoordW'(signed'({in_q.pos_y, 1'b0}));
    end else begin
      x2_d = CoordW'(signed'({xo_q, 1'b0})) + signed'({2'b00, prod_x_q});
      y2_d = CoordW'(signed'({yt_q, 1'b0})) - signed'({2'b00, prod_y_q});
    end
  end

  // Box count
  always_comb begin
    cnt_d = cnt_q;
    case (in_q.mode)
      MODE_ADD:   if (!full) cnt_d = CntW'(cnt_q + 1'b1);
      MODE_CLEAR: cnt_d = '0;
      default:    cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep) begin
      cnt_q <= cnt_d;
    end
  end

  // Box table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep && (in_q.mode == MODE_ADD) && !full) begin
      mem[cnt_q[IdxW-1:0]] <= new_box;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_idx_q[IdxW-1:0]];
    cmp_idx_q <= rd_idx_q[IdxW-1:0];
  end

  // Scan pointer stops at the count, so it never runs past the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.prep) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.sum || cmd_i.scan) begin
      cmp_vld_q <= (rd_idx_q < cnt_q);
      if (rd_idx_q < cnt_q) begin
        rd_idx_q <= CntW'(rd_idx_q + 1'b1);
      end
    end
  end

  // Doubled edges: low inclusive, high exclusive
  always_comb begin
    lo_x = BoundW'(signed'({rd_data_q.cx, 1'b0})) - signed'({2'b00, rd_data_q.lx});
    hi_x = BoundW'(signed'({rd_data_q.cx, 1'b0})) + signed'({2'b00, rd_data_q.lx});
    lo_y = BoundW'(signed'({rd_data_q.cy, 1'b0})) - signed'({2'b00, rd_data_q.ly});
    hi_y = BoundW'(signed'({rd_data_q.cy, 1'b0})) + signed'({2'b00, rd_data_q.ly});
    in_box = (CoordW'(lo_x) <= x2_q) && (x2_q < CoordW'(hi_x)) &&
             (CoordW'(lo_y) <= y2_q) && (y2_q < CoordW'(hi_y));
  end

  assign status_o.is_query = is_query;
  assign status_o.match    = cmp_vld_q && in_box;
  assign status_o.scan_end = !cmp_vld_q;

  assign finish_upd  = cmd_i.prep && !is_query;
  assign finish_scan = cmd_i.scan && (status_o.match || status_o.scan_end);

  always_comb begin
    logic [31:0] cnt_wide;
    logic [31:0] slot_wide;
    cnt_wide  = 32'(finish_upd ? cnt_d : cnt_q);
    slot_wide = 32'(cmp_idx_q);
    res_d.hit        = finish_scan && status_o.match;
    res_d.first_slot = res_d.hit ? slot_wide[3:0] : 4'd0;
    res_d.table_full = finish_upd && (in_q.mode == MODE_ADD) && full;
    res_d.box_count  = cnt_wide[4:0];
  end

  always_ff @(posedge clk_i) begin
    if (finish_upd || finish_scan) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= cnt_q || cmd_i.prep)
    else $error("scan pointer past box count");

endmodule

// File: hw/rtl/boq_ctrl.sv
// Controller: sequences one item through the prep step and, for a query, sum and scan.
// Depends on boq_pkg; commands boq_dp.
`timescale 1ns / 1ps

module boq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  boq_pkg::status_t status_i,
  output boq_pkg::cmd_t    cmd_o,
  output logic             busy,
  output logic             res_valid_o
);
  import boq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SUM,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   res_valid_q;

  assign cmd_o.capture = start && !busy_q;
  assign cmd_o.prep    = (state_q == ST_PREP);
  assign cmd_o.sum     = (state_q == ST_SUM);
  assign cmd_o.scan    = (state_q == ST_SCAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            busy_q  <= 1'b1;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (status_i.is_query) begin
            state_q <= ST_SUM;
          end else begin
            res_valid_q <= 1'b1;
            busy_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        ST_SUM: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (status_i.match || status_i.scan_end) begin
            res_valid_q <= 1'b1;
            busy_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          busy_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy        = busy_q;
  assign res_valid_o = res_valid_q;

endmodule

// File: hw/rtl/box_occupancy_query.sv
// Top level of the box occupancy query block.
// Depends on boq_pkg, boq_ctrl and boq_dp.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; its single result shows
// on res_o for one cycle with res_valid_o high and cannot be held off. Busy
// falls with the result. Add and clear items pass only through the prep step;
// queries go on through sum and scan and stop at the first hit or, on a miss,
// after every stored box: the box table is scanned one box per cycle through
// its single read port. Configuration writes are applied at once.
module box_occupancy_query #(
  parameter int unsigned MAX_BOXES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  boq_pkg::in_t                 in_i,
  output logic                         res_valid_o,
  output boq_pkg::out_t                res_o,
  input  logic                         cfg_we_i,
  input  logic [boq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [boq_pkg::CfgDataW-1:0] cfg_data_i
);
  import boq_pkg::*;

  localparam int unsigned IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);

  cmd_t    cmd;
  status_t status;

  boq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy),
    .res_valid_o (res_valid_o)
  );

  boq_dp #(
    .MaxBoxes (MAX_BOXES),
    .IdxW     (IdxW),
    .CntW     (CntW)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_o      (res_o)
  );

  a_result_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !res_valid_o)
    else $error("accepted item did not raise busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.table_full) |-> res_o.box_count == 5'(MAX_BOXES) && !res_o.hit)
    else $error("refused add with table not full");

  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.hit) |-> res_o.first_slot == 4'd0)
    else $error("nonzero slot on a miss");

endmodule

// File: dv/boq_checker.sv
// Checker for the box occupancy query block: watches the item, result and
// register write channels, predicts each result and compares it.
// Depends on boq_pkg.
`timescale 1ns / 1ps

module boq_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  boq_pkg::in_t                 item_i,
  input  logic                         res_valid_i,
  input  boq_pkg::out_t                res_i,
  input  logic                         cfg_we_i,
  input  logic [boq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [boq_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import boq_pkg::*;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned ReportMax  = 10;

  box_t               boxes [TableDepth];
  int unsigned        n_stored;
  logic signed [15:0] x_left;
  logic signed [15:0] y_upper;
  logic        [11:0] cell_mm;
  out_t               awaited_results [$];
  out_t               want;
  int unsigned        fails;

  // Doubled edges: low edge inclusive, high edge exclusive.
  function automatic bit box_covers(box_t b, longint x2, longint y2);
    longint cx2;
    longint cy2;
    cx2 = 2 * longint'(b.cx);
    cy2 = 2 * longint'(b.cy);
    return (cx2 - longint'(b.lx) <= x2) && (x2 < cx2 + longint'(b.lx)) &&
           (cy2 - longint'(b.ly) <= y2) && (y2 < cy2 + longint'(b.ly));
  endfunction

  // Applies one item to the mirrored table and returns its result.
  function automatic out_t occupancy_step(in_t it);
    out_t   r;
    longint x2;
    longint y2;
    bit     found;
    r = '0;
    case (it.mode)
      MODE_ADD: begin
        if (n_stored < TableDepth) begin
          boxes[n_stored].cx = it.pos_x;
          boxes[n_stored].cy = it.pos_y;
          boxes[n_stored].lx = it.len_x;
          boxes[n_stored].ly = it.len_y;
          n_stored++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      MODE_CLEAR: begin
        n_stored = 0;
      end
      default: begin
        if (it.mode == MODE_POINT) begin
          x2 = 2 * longint'(it.pos_x);
          y2 = 2 * longint'(it.pos_y);
        end else begin
          // cell center, doubled; rows run down from the top edge
          x2 = 2 * longint'(x_left) + (2 * longint'(it.cell_col) + 1) * longint'(cell_mm);
          y2 = 2 * longint'(y_upper) - (2 * longint'(it.cell_row) + 1) * longint'(cell_mm);
        end
        found = 1'b0;
        for (int k = 0; k < n_stored; k++) begin
          if (!found && box_covers(boxes[k], x2, y2)) begin
            found        = 1'b1;
            r.hit        = 1'b1;
            r.first_slot = k[3:0];
          end
        end
      end
    endcase
    r.box_count = n_stored[4:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      n_stored = 0;
      x_left   = XOriginRst;
      y_upper  = YTopRst;
      cell_mm  = CellSizeRst;
      fails    = 0;
      awaited_results.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (res_valid_i) begin
        if (awaited_results.size() == 0) begin
          if (fails < ReportMax) begin
            $display("%t: result with no item pending: hit=%0d slot=%0d full=%0d count=%0d",
                     $realtime, res_i.hit, res_i.first_slot, res_i.table_full,
                     res_i.box_count);
          end
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (res_i.hit !== want.hit || res_i.first_slot !== want.first_slot ||
              res_i.table_full !== want.table_full ||
              res_i.box_count !== want.box_count) begin
            if (fails < ReportMax) begin
              $display("%t: mismatch exp hit=%0d slot=%0d full=%0d count=%0d",
                       $realtime, want.hit, want.first_slot, want.table_full,
                       want.box_count);
              $display("%t:          got hit=%0d slot=%0d full=%0d count=%0d",
                       $realtime, res_i.hit, res_i.first_slot, res_i.table_full,
                       res_i.box_count);
            end
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        awaited_results.insert(awaited_results.size(), occupancy_step(item_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_X_ORIGIN:  x_left  = cfg_data_i;
          CFG_Y_TOP:     y_upper = cfg_data_i;
          CFG_CELL_SIZE: cell_mm = cfg_data_i[11:0];
          default: ;
        endcase
      end
      pending_o    <= awaited_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: dv/tb_box_occupancy_query.sv
// Testbench top for box_occupancy_query: clock, reset, directed and random
// items, register phases and the verdict. Depends on boq_pkg, boq_checker.
`timescale 1ns / 1ps

module tb_box_occupancy_query;
  import boq_pkg::*;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned PerPhase   = 230;
  localparam int unsigned NumPhases  = 5;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start      = 1'b0;
  logic                busy;
  in_t                 item       = '0;
  logic                res_valid;
  out_t                res;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int unsigned         fail_count;
  int unsigned         pending;

  // stimulus-side view of the table, used to aim queries and to fill the table
  int bx [$];
  int by [$];
  int bw [$];
  int bh [$];
  int br [$];
  int bc [$];
  int cur_xo;
  int cur_yt;
  int cur_cs;
  int idle_pct;
  int phase_sent;

  always #5 clk_i = ~clk_i;

  box_occupancy_query #(
    .MAX_BOXES(TableDepth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (item),
    .res_valid_o(res_valid),
    .res_o      (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  boq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item),
    .res_valid_i (res_valid),
    .res_i       (res),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic in_t mk_item(mode_e m, int px, int py, int lx, int ly, int row, int col);
    in_t it;
    it.mode     = m;
    it.pos_x    = px[15:0];
    it.pos_y    = py[15:0];
    it.len_x    = lx[15:0];
    it.len_y    = ly[15:0];
    it.cell_row = row[9:0];
    it.cell_col = col[9:0];
    return it;
  endfunction

  function automatic in_t noise_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(in_t)-1:0];
  endfunction

  // Presents one item and returns right after the edge that takes it.
  task automatic issue(in_t it, int trow, int tcol);
    int n;
    if ($urandom_range(99) < idle_pct) begin
      n = $urandom_range(1, 24);
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy);
    phase_sent++;
    case (it.mode)
      MODE_ADD: begin
        if (bx.size() < TableDepth) begin
          bx = {bx, int'(it.pos_x)};
          by = {by, int'(it.pos_y)};
          bw = {bw, int'(it.len_x)};
          bh = {bh, int'(it.len_y)};
          br = {br, trow};
          bc = {bc, tcol};
        end
      end
      MODE_CLEAR: begin
        bx.delete(); by.delete(); bw.delete(); bh.delete(); br.delete(); bc.delete();
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  task automatic configure(int xo, int yt, logic [15:0] cs_data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_X_ORIGIN;
    cfg_data_i <= xo[15:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_Y_TOP;
    cfg_data_i <= yt[15:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CELL_SIZE;
    cfg_data_i <= cs_data;
    @(posedge clk_i);
    // index with no register behind it must change nothing
    cfg_idx_i  <= CfgUnused;
    cfg_data_i <= 16'($urandom());
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_xo = int'($signed(xo[15:0]));
    cur_yt = int'($signed(yt[15:0]));
    cur_cs = int'(cs_data[11:0]);
  endtask

  task automatic rand_add();
    int row;
    int col;
    int maxc;
    int maxr;
    int cx;
    int cy;
    int lx;
    int ly;
    int pick;
    pick = $urandom_range(99);
    row  = -1;
    col  = -1;
    if (pick < 50) begin
      // box centered on a grid cell that lies in range
      if (cur_cs == 0) begin
        maxc = 1023;
        maxr = 1023;
      end else begin
        maxc = (32767 - cur_xo) / cur_cs - 1;
        maxr = (cur_yt + 32768) / cur_cs - 1;
      end
      maxc = (maxc < 0) ? 0 : (maxc > 1023) ? 1023 : maxc;
      maxr = (maxr < 0) ? 0 : (maxr > 1023) ? 1023 : maxr;
      col = $urandom_range(0, maxc);
      row = $urandom_range(0, maxr);
      cx  = cur_xo + col * cur_cs + cur_cs / 2;
      cy  = cur_yt - row * cur_cs - cur_cs / 2;
      lx  = (cur_cs == 0) ? $urandom_range(0, 40) : $urandom_range(0, 2 * cur_cs + 4);
      ly  = (cur_cs == 0) ? $urandom_range(0, 40) : $urandom_range(0, 2 * cur_cs + 4);
    end else if (pick < 90) begin
      cx = $urandom_range(0, 4000);
      cx = cx - 2000;
      cy = $urandom_range(0, 4000);
      cy = cy - 2000;
      lx = $urandom_range(0, 1000);
      ly = $urandom_range(0, 1000);
    end else begin
      cx = $urandom();
      cy = $urandom();
      lx = $urandom_range(0, 65535);
      ly = $urandom_range(0, 65535);
    end
    issue(mk_item(MODE_ADD, cx, cy, lx, ly, $urandom(), $urandom()), row, col);
  endtask

  // Near box edge: at or just below low, first above, below low, or low to first above.
  function automatic int near_edge(int c, int len);
    case ($urandom_range(3))
      0:       return c - (len + 1) / 2;
      1:       return c + (len + 1) / 2;
      2:       return c - (len + 1) / 2 - 1;
      default: return c - len / 2 + $urandom_range(0, len);
    endcase
  endfunction

  task automatic rand_point();
    int k;
    int px;
    int py;
    if (bx.size() == 0 || $urandom_range(99) < 20) begin
      px = $urandom();
      py = $urandom();
    end else begin
      k  = $urandom_range(0, bx.size() - 1);
      px = near_edge(bx[k], bw[k]);
      py = near_edge(by[k], bh[k]);
    end
    issue(mk_item(MODE_POINT, px, py, $urandom(), $urandom(), $urandom(), $urandom()), -1, -1);
  endtask

  task automatic rand_cell();
    int k;
    int row;
    int col;
    row = $urandom_range(0, 1023);
    col = $urandom_range(0, 1023);
    if (bx.size() != 0 && $urandom_range(99) < 75) begin
      k = $urandom_range(0, bx.size() - 1);
      if (br[k] >= 0) begin
        row = br[k] + $urandom_range(0, 2) - 1;
        col = bc[k] + $urandom_range(0, 2) - 1;
        row = (row < 0) ? 0 : (row > 1023) ? 1023 : row;
        col = (col < 0) ? 0 : (col > 1023) ? 1023 : col;
      end
    end
    issue(mk_item(MODE_CELL, $urandom(), $urandom(), $urandom(), $urandom(), row, col), -1, -1);
  endtask

  task automatic set_phase(int p);
    int xo;
    int yt;
    case (p)
      0: configure(-32768, 32767, 16'h0001);
      1: configure(32767, -32768, 16'h0FFF);
      2: configure($urandom(), $urandom(), 16'hF000);   // cell size zero
      3: configure(-10000, 10000, 16'h0064);
      default: begin
        xo = $urandom_range(0, 4000);
        yt = $urandom_range(0, 4000);
        configure(xo - 2000, yt - 2000, {4'($urandom()), 12'($urandom_range(1, 300))});
      end
    endcase
    case (p % 4)
      1:       idle_pct = 46;
      3:       idle_pct = 31;
      default: idle_pct = 0;
    endcase
    if (p == 4) idle_pct = 46;
  endtask

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    idle_pct   = 0;
    phase_sent = 0;
    cur_xo     = -10000;
    cur_yt     = 10000;
    cur_cs     = 100;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, register values from reset
    issue(mk_item(MODE_POINT, 0, 0, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_CLEAR, -1, -1, -1, -1, -1, -1), -1, -1);
    issue(mk_item(MODE_ADD, 0, 0, 100, 100, 0, 0), -1, -1);
    issue(mk_item(MODE_POINT, -50, -50, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_POINT, 50, 0, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_POINT, 49, 49, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_ADD, 200, 200, 0, 10, 0, 0), -1, -1);
    issue(mk_item(MODE_POINT, 200, 200, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_ADD, -9950, 9950, 100, 100, 1023, 1023), 0, 0);
    issue(mk_item(MODE_CELL, 0, 0, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_CELL, -1, -1, -1, -1, 0, 1), -1, -1);
    issue(mk_item(MODE_CELL, 0, 0, 0, 0, 1023, 1023), -1, -1);
    issue(mk_item(MODE_ADD, -32768, -32768, 65535, 65535, 0, 0), -1, -1);
    issue(mk_item(MODE_ADD, 32767, 32767, 65535, 65535, 0, 0), -1, -1);
    issue(mk_item(MODE_POINT, -32768, -32768, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_POINT, 32767, 32767, 0, 0, 0, 0), -1, -1);
    // fill up, then overflow the table
    while (bx.size() < TableDepth)
      issue(mk_item(MODE_ADD, 30000, 30000 - bx.size(), 2, 2, 0, 0), -1, -1);
    issue(mk_item(MODE_ADD, 1, 1, 1, 1, 0, 0), -1, -1);
    issue(mk_item(MODE_POINT, 30000, 29985, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_POINT, 1000, 1000, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_CLEAR, 0, 0, 0, 0, 0, 0), -1, -1);
    issue(mk_item(MODE_POINT, 0, 0, 0, 0, 0, 0), -1, -1);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      set_phase(p);
      phase_sent = 0;
      while (phase_sent < PerPhase) begin
        if ($urandom_range(99) < 12) begin
          issue(noise_item(), -1, -1);
        end else begin
          if ($urandom_range(99) < 35)
            issue(mk_item(MODE_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom()), -1, -1);
          repeat ($urandom_range(0, 9)) rand_add();
          repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(1)) rand_point();
            else rand_cell();
          end
        end
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    for (int w = 0; w < 2000 && pending != 0; w++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
